FILE: rtl/kpv_pkg.sv
`timescale 1ns / 1ps
package kpv_pkg;

	// action codes of an input request
	localparam logic [1:0] ACT_PREDICT = 2'd0;
	localparam logic [1:0] ACT_UPDATE  = 2'd1;
	localparam logic [1:0] ACT_RELOAD  = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_Q_POS_POS     = 3'd0;
	localparam logic [2:0] REG_Q_POS_VEL     = 3'd1;
	localparam logic [2:0] REG_Q_VEL_POS     = 3'd2;
	localparam logic [2:0] REG_Q_VEL_VEL     = 3'd3;
	localparam logic [2:0] REG_MEAS_VARIANCE = 3'd4;
	localparam logic [2:0] REG_TIME_STEP     = 3'd5;
	localparam logic [2:0] REG_INIT_POSITION = 3'd6;
	localparam logic [2:0] REG_INIT_VELOCITY = 3'd7;

	// configuration reset values
	localparam logic [30:0] MEAS_VARIANCE_RST = 31'd65536;
	localparam logic [30:0] TIME_STEP_RST     = 31'd655;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC,
		ST_WAIT,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [4:0] {
		SRC_ZERO,
		SRC_POS,
		SRC_VEL,
		SRC_P00,
		SRC_P01,
		SRC_P10,
		SRC_P11,
		SRC_T0,
		SRC_T1,
		SRC_T2,
		SRC_T3,
		SRC_DT,
		SRC_Q00,
		SRC_Q01,
		SRC_Q10,
		SRC_Q11,
		SRC_R,
		SRC_INITP,
		SRC_INITV,
		SRC_ACC,
		SRC_MEAS,
		SRC_HALF
	} src_t;

	typedef enum logic [3:0] {
		DST_POS,
		DST_VEL,
		DST_P00,
		DST_P01,
		DST_P10,
		DST_P11,
		DST_T0,
		DST_T1,
		DST_T2,
		DST_T3
	} dst_t;

	typedef struct packed {
		op_t  op;
		src_t a;
		src_t b;
		dst_t d;
		logic last;
	} uop_t;

	localparam int UCODE_LEN = 39;
	localparam int PC_W      = 6;

	localparam logic [PC_W-1:0] PC_PREDICT = 6'd0;
	localparam logic [PC_W-1:0] PC_UPDATE  = 6'd20;
	localparam logic [PC_W-1:0] PC_RELOAD  = 6'd36;
	localparam logic [PC_W-1:0] PC_NOP     = 6'd38;

	// microprogram: predict, update, reload, unused action
	localparam uop_t UCODE [UCODE_LEN] = '{
		'{OP_MUL, SRC_ACC,  SRC_DT,   DST_T0,  1'b0},
		'{OP_MUL, SRC_P11,  SRC_DT,   DST_T1,  1'b0},
		'{OP_MUL, SRC_VEL,  SRC_DT,   DST_T2,  1'b0},
		'{OP_ADD, SRC_POS,  SRC_T2,   DST_T2,  1'b0},
		'{OP_MUL, SRC_T0,   SRC_DT,   DST_T3,  1'b0},
		'{OP_MUL, SRC_HALF, SRC_T3,   DST_T3,  1'b0},
		'{OP_ADD, SRC_T2,   SRC_T3,   DST_POS, 1'b0},
		'{OP_ADD, SRC_VEL,  SRC_T0,   DST_VEL, 1'b0},
		'{OP_MUL, SRC_P10,  SRC_DT,   DST_T2,  1'b0},
		'{OP_ADD, SRC_P00,  SRC_T2,   DST_T2,  1'b0},
		'{OP_MUL, SRC_P01,  SRC_DT,   DST_T3,  1'b0},
		'{OP_ADD, SRC_T2,   SRC_T3,   DST_T2,  1'b0},
		'{OP_MUL, SRC_T1,   SRC_DT,   DST_T3,  1'b0},
		'{OP_ADD, SRC_T2,   SRC_T3,   DST_T2,  1'b0},
		'{OP_ADD, SRC_T2,   SRC_Q00,  DST_P00, 1'b0},
		'{OP_ADD, SRC_P01,  SRC_T1,   DST_T2,  1'b0},
		'{OP_ADD, SRC_T2,   SRC_Q01,  DST_P01, 1'b0},
		'{OP_ADD, SRC_P10,  SRC_T1,   DST_T2,  1'b0},
		'{OP_ADD, SRC_T2,   SRC_Q10,  DST_P10, 1'b0},
		'{OP_ADD, SRC_P11,  SRC_Q11,  DST_P11, 1'b1},
		'{OP_ADD, SRC_P00,  SRC_R,    DST_T0,  1'b0},
		'{OP_DIV, SRC_P00,  SRC_T0,   DST_T1,  1'b0},
		'{OP_DIV, SRC_P10,  SRC_T0,   DST_T2,  1'b0},
		'{OP_SUB, SRC_MEAS, SRC_POS,  DST_T3,  1'b0},
		'{OP_MUL, SRC_T1,   SRC_T3,   DST_T0,  1'b0},
		'{OP_ADD, SRC_POS,  SRC_T0,   DST_POS, 1'b0},
		'{OP_MUL, SRC_T2,   SRC_T3,   DST_T0,  1'b0},
		'{OP_ADD, SRC_VEL,  SRC_T0,   DST_VEL, 1'b0},
		'{OP_MUL, SRC_T2,   SRC_P00,  DST_T0,  1'b0},
		'{OP_SUB, SRC_P10,  SRC_T0,   DST_P10, 1'b0},
		'{OP_MUL, SRC_T1,   SRC_P00,  DST_T0,  1'b0},
		'{OP_SUB, SRC_P00,  SRC_T0,   DST_P00, 1'b0},
		'{OP_MUL, SRC_T2,   SRC_P01,  DST_T0,  1'b0},
		'{OP_SUB, SRC_P11,  SRC_T0,   DST_P11, 1'b0},
		'{OP_MUL, SRC_T1,   SRC_P01,  DST_T0,  1'b0},
		'{OP_SUB, SRC_P01,  SRC_T0,   DST_P01, 1'b1},
		'{OP_ADD, SRC_INITP, SRC_ZERO, DST_POS, 1'b0},
		'{OP_ADD, SRC_INITV, SRC_ZERO, DST_VEL, 1'b1},
		'{OP_ADD, SRC_ZERO, SRC_ZERO, DST_T0,  1'b1}
	};

endpackage

FILE: rtl/kpv_ifs.sv
`timescale 1ns / 1ps
// input request channel
interface kpv_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [31:0] accel;
	logic signed [31:0] measurement;
	modport source(output valid, action, accel, measurement, input ready);
	modport sink(input valid, action, accel, measurement, output ready);
endinterface

// result channel
interface kpv_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position;
	logic signed [31:0] velocity;
	logic               saturated;
	modport source(output valid, position, velocity, saturated, input ready);
	modport sink(input valid, position, velocity, saturated, output ready);
endinterface

// configuration write channel
interface kpv_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/kpv_mul.sv
`timescale 1ns / 1ps
// bit-serial saturating fixed-point multiplier, one multiplier bit per cycle
module kpv_mul #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic                done,
	output logic signed [W-1:0] res,
	output logic                ovf
);

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  ma_q;
	logic [2*W-1:0] p_q;
	logic          neg_q;
	logic          done_q;
	logic signed [W-1:0] res_q;
	logic          ovf_q;

	logic [W:0]     step_sum;
	logic [2*W-1:0] q_full;
	logic [2*W-1:0] lim;
	logic [W-1:0]   q_mag;
	logic           q_ovf;

	// add-shift step and final truncate, saturate
	always_comb begin
		step_sum = {1'b0, p_q[2*W-1:W]} + (p_q[0] ? {1'b0, ma_q} : '0);
		q_full   = p_q >> F;
		lim      = (2*W)'({1'b0, {(W-1){1'b1}}}) + (2*W)'(neg_q);
		q_ovf    = q_full > lim;
		q_mag    = q_ovf ? lim[W-1:0] : q_full[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(W)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a[W-1] ? W'(-a) : W'(a);
			p_q   <= {{W{1'b0}}, (b[W-1] ? W'(-b) : W'(b))};
			neg_q <= a[W-1] ^ b[W-1];
		end else if (busy_q) begin
			if (cnt_q == CW'(W)) begin
				res_q <= neg_q ? -$signed(q_mag) : $signed(q_mag);
				ovf_q <= q_ovf;
			end else begin
				p_q <= {step_sum, p_q[W-1:1]};
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign ovf  = ovf_q;

endmodule

FILE: rtl/kpv_div.sv
`timescale 1ns / 1ps
// bit-serial restoring fixed-point divider, one quotient bit per cycle
module kpv_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic                done,
	output logic signed [W-1:0] res,
	output logic                ovf
);

	localparam int N  = W + F;
	localparam int CW = $clog2(N + 1);

	logic          busy_q;
	logic          zero_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  d_q;
	logic [W-1:0]  rem_q;
	logic [N-1:0]  q_q;
	logic          neg_q;
	logic          done_q;
	logic signed [W-1:0] res_q;
	logic          ovf_q;

	logic [W:0]   r2;
	logic [W:0]   diff;
	logic         ge;
	logic [N-1:0] lim;
	logic         q_ovf;
	logic [W-1:0] q_mag;
	logic [W-1:0] ma;
	logic [W-1:0] mb;

	// trial subtract and final saturate
	always_comb begin
		ma    = a[W-1] ? W'(-a) : W'(a);
		mb    = b[W-1] ? W'(-b) : W'(b);
		r2    = {rem_q, q_q[N-1]};
		diff  = r2 - {1'b0, d_q};
		ge    = r2 >= {1'b0, d_q};
		lim   = N'({1'b0, {(W-1){1'b1}}}) + N'(neg_q);
		q_ovf = q_q > lim;
		q_mag = q_ovf ? lim[W-1:0] : q_q[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (zero_q || cnt_q == CW'(N)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			d_q    <= mb;
			zero_q <= mb == '0;
			rem_q  <= '0;
			q_q    <= {ma, {F{1'b0}}};
			neg_q  <= a[W-1] ^ b[W-1];
		end else if (busy_q) begin
			if (zero_q) begin
				res_q <= '0;
				ovf_q <= 1'b1;
			end else if (cnt_q == CW'(N)) begin
				res_q <= neg_q ? -$signed(q_mag) : $signed(q_mag);
				ovf_q <= q_ovf;
			end else begin
				rem_q <= ge ? diff[W-1:0] : r2[W-1:0];
				q_q   <= {q_q[N-2:0], ge};
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign ovf  = ovf_q;

endmodule

FILE: rtl/kalman_pos_vel_filter_top.sv
`timescale 1ns / 1ps
// channel   direction  payload
// in_ch     sink       action[1:0], accel[31:0], measurement[31:0]
// out_ch    source     position[31:0], velocity[31:0], saturated
// cfg       sink       index[2:0], data[31:0]
//
// one request at a time, run as a microprogram on a shared bit-serial multiplier
// and divider
// reset loads the configuration defaults, clears covariance and the estimate to zero
// a result held by a stalled sink does not block the next request, only its end
module kalman_pos_vel_filter_top #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	kpv_in_if.sink      in_ch,
	kpv_out_if.source   out_ch,
	kpv_cfg_if.sink     cfg
);

	localparam int W  = DATA_WIDTH;
	localparam int XW = (DATA_WIDTH > 33) ? DATA_WIDTH : 33;
	localparam logic signed [XW-1:0] VMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] VMIN_X = ~VMAX_X;
	localparam logic [W-1:0] HALF_W = {{(W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

	typedef struct packed {
		logic signed [W-1:0] v;
		logic                c;
	} opnd_t;

	// configuration registers
	logic [30:0]        q00_q, q11_q, r_q, dt_q;
	logic signed [31:0] q01_q, q10_q, initp_q, initv_q;

	// filter state and temporaries
	logic signed [W-1:0] pos_q, vel_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [W-1:0] t0_q, t1_q, t2_q, t3_q;

	// sequencer
	kpv_pkg::state_t         state_q, state_d;
	logic [kpv_pkg::PC_W-1:0] pc_q;
	kpv_pkg::uop_t           uop;
	logic signed [31:0]      acc_q, meas_q;
	logic signed [W-1:0]     opa_q, opb_q;
	logic                    clip_q;

	// result register
	logic                out_valid_q;
	logic signed [31:0]  out_pos_q, out_vel_q;
	logic                out_sat_q;

	// control
	logic                in_ready;
	logic                mul_start, div_start;
	logic                wb_en;
	logic signed [W-1:0] wb_val;
	logic                wb_clip;
	logic                out_load;
	logic [kpv_pkg::PC_W-1:0] start_pc;
	opnd_t               fa, fb;

	logic                mul_done, mul_ovf, div_done, div_ovf;
	logic signed [W-1:0] mul_res, div_res;
	logic signed [W:0]   sum;

	function automatic logic signed [XW-1:0] raw_of(input kpv_pkg::src_t s);
		logic signed [XW-1:0] r;
		case (s)
			kpv_pkg::SRC_POS:   r = XW'(pos_q);
			kpv_pkg::SRC_VEL:   r = XW'(vel_q);
			kpv_pkg::SRC_P00:   r = XW'(p00_q);
			kpv_pkg::SRC_P01:   r = XW'(p01_q);
			kpv_pkg::SRC_P10:   r = XW'(p10_q);
			kpv_pkg::SRC_P11:   r = XW'(p11_q);
			kpv_pkg::SRC_T0:    r = XW'(t0_q);
			kpv_pkg::SRC_T1:    r = XW'(t1_q);
			kpv_pkg::SRC_T2:    r = XW'(t2_q);
			kpv_pkg::SRC_T3:    r = XW'(t3_q);
			kpv_pkg::SRC_DT:    r = XW'(dt_q);
			kpv_pkg::SRC_Q00:   r = XW'(q00_q);
			kpv_pkg::SRC_Q01:   r = XW'(q01_q);
			kpv_pkg::SRC_Q10:   r = XW'(q10_q);
			kpv_pkg::SRC_Q11:   r = XW'(q11_q);
			kpv_pkg::SRC_R:     r = XW'(r_q);
			kpv_pkg::SRC_INITP: r = XW'(initp_q);
			kpv_pkg::SRC_INITV: r = XW'(initv_q);
			kpv_pkg::SRC_ACC:   r = XW'(acc_q);
			kpv_pkg::SRC_MEAS:  r = XW'(meas_q);
			kpv_pkg::SRC_HALF:  r = XW'(HALF_W);
			default:            r = '0;
		endcase
		return r;
	endfunction

	function automatic opnd_t fetch(input kpv_pkg::src_t s);
		logic signed [XW-1:0] r;
		opnd_t o;
		r = raw_of(s);
		if (r > VMAX_X) begin
			o.v = VMAX_X[W-1:0];
			o.c = 1'b1;
		end else if (r < VMIN_X) begin
			o.v = VMIN_X[W-1:0];
			o.c = 1'b1;
		end else begin
			o.v = r[W-1:0];
			o.c = 1'b0;
		end
		return o;
	endfunction

	function automatic logic signed [W-1:0] sat_init(input logic signed [31:0] v);
		logic signed [XW-1:0] r;
		r = XW'(v);
		if (r > VMAX_X) begin
			return VMAX_X[W-1:0];
		end else if (r < VMIN_X) begin
			return VMIN_X[W-1:0];
		end
		return r[W-1:0];
	endfunction

	assign uop = kpv_pkg::UCODE[pc_q];

	// saturating operand fetch and add/sub
	always_comb begin
		fa  = fetch(uop.a);
		fb  = fetch(uop.b);
		sum = (uop.op == kpv_pkg::OP_SUB) ? ($signed({opa_q[W-1], opa_q}) - opb_q)
		                                  : ($signed({opa_q[W-1], opa_q}) + opb_q);
	end

	// start address by action
	always_comb begin
		case (in_ch.action)
			kpv_pkg::ACT_PREDICT: start_pc = kpv_pkg::PC_PREDICT;
			kpv_pkg::ACT_UPDATE:  start_pc = kpv_pkg::PC_UPDATE;
			kpv_pkg::ACT_RELOAD:  start_pc = kpv_pkg::PC_RELOAD;
			default:              start_pc = kpv_pkg::PC_NOP;
		endcase
	end

	// shared serial units
	kpv_mul #(.W(W), .F(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (opa_q),
		.b      (opb_q),
		.done   (mul_done),
		.res    (mul_res),
		.ovf    (mul_ovf)
	);

	kpv_div #(.W(W), .F(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (opa_q),
		.b      (opb_q),
		.done   (div_done),
		.res    (div_res),
		.ovf    (div_ovf)
	);

	// next state and control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		wb_en     = 1'b0;
		wb_val    = sum[W-1:0];
		wb_clip   = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			kpv_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_ch.valid) begin
					state_d = kpv_pkg::ST_FETCH;
				end
			end
			kpv_pkg::ST_FETCH: begin
				state_d = kpv_pkg::ST_EXEC;
			end
			kpv_pkg::ST_EXEC: begin
				case (uop.op)
					kpv_pkg::OP_MUL: begin
						mul_start = 1'b1;
						state_d   = kpv_pkg::ST_WAIT;
					end
					kpv_pkg::OP_DIV: begin
						div_start = 1'b1;
						state_d   = kpv_pkg::ST_WAIT;
					end
					default: begin
						wb_en = 1'b1;
						if (sum[W] != sum[W-1]) begin
							wb_clip = 1'b1;
							wb_val  = sum[W] ? VMIN_X[W-1:0] : VMAX_X[W-1:0];
						end
						state_d = uop.last ? kpv_pkg::ST_FINISH : kpv_pkg::ST_FETCH;
					end
				endcase
			end
			kpv_pkg::ST_WAIT: begin
				if (mul_done || div_done) begin
					wb_en   = 1'b1;
					wb_val  = mul_done ? mul_res : div_res;
					wb_clip = mul_done ? mul_ovf : div_ovf;
					state_d = uop.last ? kpv_pkg::ST_FINISH : kpv_pkg::ST_FETCH;
				end
			end
			kpv_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = kpv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kpv_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kpv_pkg::ST_IDLE;
			pc_q    <= '0;
			clip_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_ready && in_ch.valid) begin
				pc_q   <= start_pc;
				clip_q <= 1'b0;
			end else if (state_q == kpv_pkg::ST_FETCH) begin
				clip_q <= clip_q | fa.c | fb.c;
			end else if (wb_en) begin
				clip_q <= clip_q | wb_clip;
				if (!uop.last) begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

	// request payload and operand registers
	always_ff @(posedge clk) begin
		if (in_ready && in_ch.valid) begin
			acc_q  <= in_ch.accel;
			meas_q <= in_ch.measurement;
		end
		if (state_q == kpv_pkg::ST_FETCH) begin
			opa_q <= fa.v;
			opb_q <= fb.v;
		end
	end

	// state write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= sat_init('0);
			vel_q <= sat_init('0);
			p00_q <= '0;
			p01_q <= '0;
			p10_q <= '0;
			p11_q <= '0;
		end else if (wb_en) begin
			case (uop.d)
				kpv_pkg::DST_POS: pos_q <= wb_val;
				kpv_pkg::DST_VEL: vel_q <= wb_val;
				kpv_pkg::DST_P00: p00_q <= wb_val;
				kpv_pkg::DST_P01: p01_q <= wb_val;
				kpv_pkg::DST_P10: p10_q <= wb_val;
				kpv_pkg::DST_P11: p11_q <= wb_val;
				default: ;
			endcase
		end
	end

	// temporaries
	always_ff @(posedge clk) begin
		if (wb_en) begin
			case (uop.d)
				kpv_pkg::DST_T0: t0_q <= wb_val;
				kpv_pkg::DST_T1: t1_q <= wb_val;
				kpv_pkg::DST_T2: t2_q <= wb_val;
				kpv_pkg::DST_T3: t3_q <= wb_val;
				default: ;
			endcase
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q00_q   <= '0;
			q01_q   <= '0;
			q10_q   <= '0;
			q11_q   <= '0;
			r_q     <= kpv_pkg::MEAS_VARIANCE_RST;
			dt_q    <= kpv_pkg::TIME_STEP_RST;
			initp_q <= '0;
			initv_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				kpv_pkg::REG_Q_POS_POS:     q00_q   <= cfg.data[30:0];
				kpv_pkg::REG_Q_POS_VEL:     q01_q   <= cfg.data;
				kpv_pkg::REG_Q_VEL_POS:     q10_q   <= cfg.data;
				kpv_pkg::REG_Q_VEL_VEL:     q11_q   <= cfg.data[30:0];
				kpv_pkg::REG_MEAS_VARIANCE: r_q     <= cfg.data[30:0];
				kpv_pkg::REG_TIME_STEP:     dt_q    <= cfg.data[30:0];
				kpv_pkg::REG_INIT_POSITION: initp_q <= cfg.data;
				kpv_pkg::REG_INIT_VELOCITY: initv_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pos_q <= 32'(pos_q);
			out_vel_q <= 32'(vel_q);
			out_sat_q <= clip_q;
		end
	end

	assign in_ch.ready     = in_ready;
	assign cfg.ready       = 1'b1;
	assign out_ch.valid    = out_valid_q;
	assign out_ch.position = out_pos_q;
	assign out_ch.velocity = out_vel_q;
	assign out_ch.saturated = out_sat_q;

	// unit completions come only while the sequencer waits for them
	assert property (@(posedge clk) disable iff (!arst_n)
		(mul_done || div_done) |-> state_q == kpv_pkg::ST_WAIT)
		else $error("serial unit completion outside wait");

	// a new result is only loaded after the last microinstruction
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> $past(uop.last))
		else $error("result loaded before end of microprogram");

	// program counter stays inside the microprogram
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(pc_q) < kpv_pkg::UCODE_LEN)
		else $error("microprogram counter out of range");

endmodule
